// ===== hw/rtl/first_fit_segment_allocator_macros.svh =====
// Assertion macros for the first-fit segment allocator.
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

`define FFSA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define FFSA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define FFSA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)

`define FFSA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/ffsa_pkg.sv =====
`default_nettype none

package ffsa_pkg;

   localparam logic [1:0] FN_ALLOC  = 2'd0;
   localparam logic [1:0] FN_FREE   = 2'd1;
   localparam logic [1:0] FN_RESIZE = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOFIT    = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_SCAN,
      S_NEXT,
      S_WCUR,
      S_INS_RD,
      S_INS_WR,
      S_REM_RD,
      S_REM_WR,
      S_MRG_BEGIN,
      S_MRG_LD,
      S_MRG_NX,
      S_MRG_CHK,
      S_DONE
   } state_type;

   typedef enum logic [2:0] {
      OP_ALLOC,
      OP_FREE,
      OP_RESIZE,
      OP_GROW,
      OP_SHRINK,
      OP_RELOC
   } op_type;

endpackage

`default_nettype wire

// ===== hw/rtl/first_fit_segment_allocator.sv =====
// First-fit segment allocator.
// Request channel (req_valid/req_stall) carries func, address and request_size;
// response channel (rsp_valid/rsp_stall) returns result_address and status.
// The segment table lives in one single-port-write, registered-read RAM and
// is walked by one sequencer.
// A request is taken only while the sequencer is idle. For a table of N
// segments, lookup scans 1 entry per cycle, an entry insert or remove shifts
// each moved entry through a read state and a write state, and a merge pass
// visits each entry through a next state and a check state, plus the shifts.
// The result sits in an output register; the next request is accepted while
// it waits. A stalled response holds; the sequencer waits in its final step
// until the register frees up.
// After reset the block writes the initial whole-pool free segment in its
// init state before it accepts a request.
`default_nettype none
`include "first_fit_segment_allocator_macros.svh"

module first_fit_segment_allocator #(
   parameter int POOL_BYTES   = 1024,
   parameter int MAX_SEGMENTS = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [1:0]                         req_func,
   input  wire logic [$clog2(POOL_BYTES)-1:0]      req_address,
   input  wire logic [$clog2(POOL_BYTES+1)-1:0]    req_request_size,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic      [$clog2(POOL_BYTES)-1:0]      rsp_result_address,
   output logic      [1:0]                         rsp_status
);

   localparam int AW = $clog2(POOL_BYTES);
   localparam int LW = $clog2(POOL_BYTES + 1);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int IW = $clog2(MAX_SEGMENTS);

   typedef struct packed {
      logic          used;
      logic [LW-1:0] len;
      logic [AW-1:0] start;
   } entry_type;

   localparam int EW = $bits(entry_type);

   ffsa_pkg::state_type state_ff, state_in, ret_ff, ret_in, post_ff, post_in;
   ffsa_pkg::op_type    op_ff, op_in;

   logic [CW-1:0] cnt_ff, cnt_in, idx_ff, idx_in, k_ff, k_in, old_idx_ff, old_idx_in;
   entry_type     cur_ff, cur_in, old_ff, old_in, ins_ff, ins_in;
   logic [AW-1:0] addr_ff, addr_in, delta_ff, delta_in, res_ff, res_in;
   logic [LW-1:0] size_ff, size_in;
   logic [1:0]    st_ff, st_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0] rsp_addr_ff, rsp_addr_in;
   logic [1:0]    rsp_st_ff, rsp_st_in;

   logic          ram_we;
   logic [IW-1:0] wr_idx, rd_idx;
   entry_type     wr_ent, rd_ent;
   logic [EW-1:0] ram_rd_data;

   logic          do_split;
   entry_type     spl_ent;
   logic [AW-1:0] spl_res;

   logic [LW:0]   ent_end;
   logic          hit_find, hit_fit, hit, has_next, last, full;
   logic [CW-1:0] idx_nx;
   logic [LW-1:0] grow;

   ffsa_ram #(
      .WIDTH(EW),
      .DEPTH(MAX_SEGMENTS)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(wr_idx),
      .wr_data(wr_ent),
      .rd_addr(rd_idx),
      .rd_data(ram_rd_data)
   );

   assign rd_ent   = entry_type'(ram_rd_data);
   assign ent_end  = (LW+1)'(rd_ent.start) + (LW+1)'(rd_ent.len);
   assign hit_find = ((LW+1)'(rd_ent.start) <= (LW+1)'(addr_ff))
                     && ((LW+1)'(addr_ff) < ent_end);
   assign hit_fit  = !rd_ent.used && (rd_ent.len >= size_ff);
   assign hit      = ((op_ff == ffsa_pkg::OP_FREE) || (op_ff == ffsa_pkg::OP_RESIZE))
                     ? hit_find : hit_fit;
   assign idx_nx   = idx_ff + CW'(1);
   assign last     = (idx_nx == cnt_ff);
   assign has_next = (idx_nx < cnt_ff);
   assign full     = (cnt_ff >= CW'(MAX_SEGMENTS));
   assign grow     = size_ff - cur_ff.len;

   assign req_stall          = (state_ff != ffsa_pkg::S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_status         = rsp_st_ff;

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      post_in      = post_ff;
      op_in        = op_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      old_idx_in   = old_idx_ff;
      cur_in       = cur_ff;
      old_in       = old_ff;
      ins_in       = ins_ff;
      addr_in      = addr_ff;
      delta_in     = delta_ff;
      res_in       = res_ff;
      size_in      = size_ff;
      st_in        = st_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_st_in    = rsp_st_ff;
      ram_we       = 1'b0;
      wr_idx       = idx_ff[IW-1:0];
      wr_ent       = cur_ff;
      rd_idx       = '0;
      do_split     = 1'b0;
      spl_ent      = rd_ent;
      spl_res      = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ffsa_pkg::S_INIT: begin
            ram_we       = 1'b1;
            wr_idx       = '0;
            wr_ent.used  = 1'b0;
            wr_ent.len   = LW'(POOL_BYTES);
            wr_ent.start = '0;
            state_in     = ffsa_pkg::S_IDLE;
         end
         ffsa_pkg::S_IDLE: begin
            if (req_valid) begin
               addr_in = req_address;
               size_in = req_request_size;
               res_in  = '0;
               st_in   = ffsa_pkg::ST_OK;
               idx_in  = '0;
               case (req_func)
                  ffsa_pkg::FN_ALLOC: begin
                     if (req_request_size == '0) begin
                        st_in    = ffsa_pkg::ST_NOFIT;
                        state_in = ffsa_pkg::S_DONE;
                     end else begin
                        op_in    = ffsa_pkg::OP_ALLOC;
                        state_in = ffsa_pkg::S_SCAN;
                     end
                  end
                  ffsa_pkg::FN_FREE: begin
                     op_in    = ffsa_pkg::OP_FREE;
                     state_in = ffsa_pkg::S_SCAN;
                  end
                  ffsa_pkg::FN_RESIZE: begin
                     op_in    = (req_request_size == '0) ? ffsa_pkg::OP_FREE
                                                        : ffsa_pkg::OP_RESIZE;
                     state_in = ffsa_pkg::S_SCAN;
                  end
                  default: begin
                     state_in = ffsa_pkg::S_DONE;
                  end
               endcase
            end
         end
         ffsa_pkg::S_SCAN: begin
            if (!hit) begin
               if (last) begin
                  st_in    = ((op_ff == ffsa_pkg::OP_FREE) || (op_ff == ffsa_pkg::OP_RESIZE))
                             ? ffsa_pkg::ST_NOTFOUND : ffsa_pkg::ST_NOFIT;
                  state_in = ffsa_pkg::S_DONE;
               end else begin
                  rd_idx = idx_nx[IW-1:0];
                  idx_in = idx_nx;
               end
            end else begin
               case (op_ff)
                  ffsa_pkg::OP_FREE: begin
                     ram_we      = 1'b1;
                     wr_ent      = rd_ent;
                     wr_ent.used = 1'b0;
                     state_in    = ffsa_pkg::S_DONE;
                  end
                  ffsa_pkg::OP_ALLOC: begin
                     do_split     = 1'b1;
                     spl_ent.used = 1'b1;
                     spl_res      = rd_ent.start;
                     post_in      = ffsa_pkg::S_DONE;
                  end
                  ffsa_pkg::OP_RESIZE: begin
                     delta_in = addr_ff - rd_ent.start;
                     if (size_ff > rd_ent.len) begin
                        if (has_next) begin
                           cur_in   = rd_ent;
                           op_in    = ffsa_pkg::OP_GROW;
                           rd_idx   = idx_nx[IW-1:0];
                           state_in = ffsa_pkg::S_NEXT;
                        end else begin
                           old_in     = rd_ent;
                           old_idx_in = idx_ff;
                           idx_in     = '0;
                           op_in      = ffsa_pkg::OP_RELOC;
                        end
                     end else begin
                        op_in    = ffsa_pkg::OP_SHRINK;
                        do_split = 1'b1;
                        spl_res  = addr_ff;
                        post_in  = ffsa_pkg::S_MRG_BEGIN;
                     end
                  end
                  ffsa_pkg::OP_RELOC: begin
                     if ((rd_ent.len > size_ff) && full) begin
                        st_in    = ffsa_pkg::ST_FULL;
                        state_in = ffsa_pkg::S_DONE;
                     end else begin
                        ram_we      = 1'b1;
                        wr_idx      = old_idx_ff[IW-1:0];
                        wr_ent      = old_ff;
                        wr_ent.used = 1'b0;
                        cur_in      = rd_ent;
                        cur_in.used = 1'b1;
                        res_in      = rd_ent.start + delta_ff;
                        post_in     = ffsa_pkg::S_MRG_BEGIN;
                        if (rd_ent.len > size_ff) begin
                           ins_in.used  = 1'b0;
                           ins_in.len   = rd_ent.len - size_ff;
                           ins_in.start = AW'((LW+1)'(rd_ent.start) + (LW+1)'(size_ff));
                           cur_in.len   = size_ff;
                           k_in         = cnt_ff;
                           ret_in       = ffsa_pkg::S_WCUR;
                           state_in     = ffsa_pkg::S_INS_RD;
                        end else begin
                           state_in = ffsa_pkg::S_WCUR;
                        end
                     end
                  end
                  default: begin
                     state_in = ffsa_pkg::S_DONE;
                  end
               endcase
            end
         end
         ffsa_pkg::S_NEXT: begin
            case (op_ff)
               ffsa_pkg::OP_GROW: begin
                  if (!rd_ent.used && (rd_ent.len >= grow)) begin
                     res_in     = addr_ff;
                     cur_in.len = size_ff;
                     ram_we     = 1'b1;
                     if (rd_ent.len == grow) begin
                        wr_ent     = cur_ff;
                        wr_ent.len = size_ff;
                        k_in       = idx_nx;
                        ret_in     = ffsa_pkg::S_DONE;
                        state_in   = ffsa_pkg::S_REM_RD;
                     end else begin
                        wr_idx       = idx_nx[IW-1:0];
                        wr_ent.used  = 1'b0;
                        wr_ent.len   = rd_ent.len - grow;
                        wr_ent.start = AW'((LW+1)'(rd_ent.start) + (LW+1)'(grow));
                        post_in      = ffsa_pkg::S_DONE;
                        state_in     = ffsa_pkg::S_WCUR;
                     end
                  end else begin
                     old_in     = cur_ff;
                     old_idx_in = idx_ff;
                     idx_in     = '0;
                     op_in      = ffsa_pkg::OP_RELOC;
                     state_in   = ffsa_pkg::S_SCAN;
                  end
               end
               default: begin
                  if (!rd_ent.used) begin
                     ram_we       = 1'b1;
                     wr_idx       = idx_nx[IW-1:0];
                     wr_ent.used  = 1'b0;
                     wr_ent.len   = rd_ent.len + (cur_ff.len - size_ff);
                     wr_ent.start = AW'((LW+1)'(cur_ff.start) + (LW+1)'(size_ff));
                     cur_in.len   = size_ff;
                     res_in       = (op_ff == ffsa_pkg::OP_ALLOC) ? cur_ff.start : addr_ff;
                     state_in     = ffsa_pkg::S_WCUR;
                  end else if (!full) begin
                     ins_in.used  = 1'b0;
                     ins_in.len   = cur_ff.len - size_ff;
                     ins_in.start = AW'((LW+1)'(cur_ff.start) + (LW+1)'(size_ff));
                     cur_in.len   = size_ff;
                     res_in       = (op_ff == ffsa_pkg::OP_ALLOC) ? cur_ff.start : addr_ff;
                     k_in         = cnt_ff;
                     ret_in       = ffsa_pkg::S_WCUR;
                     state_in     = ffsa_pkg::S_INS_RD;
                  end else begin
                     st_in    = ffsa_pkg::ST_FULL;
                     state_in = ffsa_pkg::S_DONE;
                  end
               end
            endcase
         end
         ffsa_pkg::S_WCUR: begin
            ram_we   = 1'b1;
            state_in = post_ff;
         end
         ffsa_pkg::S_INS_RD: begin
            if (k_ff == idx_nx) begin
               ram_we   = 1'b1;
               wr_idx   = k_ff[IW-1:0];
               wr_ent   = ins_ff;
               cnt_in   = cnt_ff + CW'(1);
               state_in = ret_ff;
            end else begin
               rd_idx   = IW'(k_ff - CW'(1));
               state_in = ffsa_pkg::S_INS_WR;
            end
         end
         ffsa_pkg::S_INS_WR: begin
            ram_we   = 1'b1;
            wr_idx   = k_ff[IW-1:0];
            wr_ent   = rd_ent;
            k_in     = k_ff - CW'(1);
            state_in = ffsa_pkg::S_INS_RD;
         end
         ffsa_pkg::S_REM_RD: begin
            if ((k_ff + CW'(1)) == cnt_ff) begin
               cnt_in   = cnt_ff - CW'(1);
               state_in = ret_ff;
            end else begin
               rd_idx   = IW'(k_ff + CW'(1));
               state_in = ffsa_pkg::S_REM_WR;
            end
         end
         ffsa_pkg::S_REM_WR: begin
            ram_we   = 1'b1;
            wr_idx   = k_ff[IW-1:0];
            wr_ent   = rd_ent;
            k_in     = k_ff + CW'(1);
            state_in = ffsa_pkg::S_REM_RD;
         end
         ffsa_pkg::S_MRG_BEGIN: begin
            idx_in = '0;
            if (cnt_ff < CW'(2)) begin
               state_in = ffsa_pkg::S_DONE;
            end else begin
               state_in = ffsa_pkg::S_MRG_LD;
            end
         end
         ffsa_pkg::S_MRG_LD: begin
            cur_in   = rd_ent;
            state_in = ffsa_pkg::S_MRG_NX;
         end
         ffsa_pkg::S_MRG_NX: begin
            if (!has_next) begin
               state_in = ffsa_pkg::S_DONE;
            end else begin
               rd_idx   = idx_nx[IW-1:0];
               state_in = ffsa_pkg::S_MRG_CHK;
            end
         end
         ffsa_pkg::S_MRG_CHK: begin
            if (!cur_ff.used && !rd_ent.used) begin
               cur_in.len = cur_ff.len + rd_ent.len;
               ram_we     = 1'b1;
               wr_ent     = cur_ff;
               wr_ent.len = cur_ff.len + rd_ent.len;
               k_in       = idx_nx;
               ret_in     = ffsa_pkg::S_MRG_NX;
               state_in   = ffsa_pkg::S_REM_RD;
            end else begin
               cur_in   = rd_ent;
               idx_in   = idx_nx;
               state_in = ffsa_pkg::S_MRG_NX;
            end
         end
         ffsa_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = res_ff;
               rsp_st_in    = st_ff;
               state_in     = ffsa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ffsa_pkg::S_IDLE;
         end
      endcase

      if (do_split) begin
         if (spl_ent.len == size_ff) begin
            cur_in   = spl_ent;
            res_in   = spl_res;
            state_in = ffsa_pkg::S_WCUR;
         end else if (has_next) begin
            cur_in   = spl_ent;
            rd_idx   = idx_nx[IW-1:0];
            state_in = ffsa_pkg::S_NEXT;
         end else if (!full) begin
            ins_in.used  = 1'b0;
            ins_in.len   = spl_ent.len - size_ff;
            ins_in.start = AW'((LW+1)'(spl_ent.start) + (LW+1)'(size_ff));
            cur_in       = spl_ent;
            cur_in.len   = size_ff;
            res_in       = spl_res;
            k_in         = cnt_ff;
            ret_in       = ffsa_pkg::S_WCUR;
            state_in     = ffsa_pkg::S_INS_RD;
         end else begin
            st_in    = ffsa_pkg::ST_FULL;
            state_in = ffsa_pkg::S_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffsa_pkg::S_INIT;
         cnt_ff       <= CW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff      <= ret_in;
      post_ff     <= post_in;
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      k_ff        <= k_in;
      old_idx_ff  <= old_idx_in;
      cur_ff      <= cur_in;
      old_ff      <= old_in;
      ins_ff      <= ins_in;
      addr_ff     <= addr_in;
      delta_ff    <= delta_in;
      res_ff      <= res_in;
      size_ff     <= size_in;
      st_ff       <= st_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_st_ff   <= rsp_st_in;
   end

   `FFSA_ASSERT_IMP(a_cnt_range, clock, reset, 1'b1, (cnt_ff != '0) && (cnt_ff <= CW'(MAX_SEGMENTS)), "segment count out of range")
   `FFSA_ASSERT_NXT(a_leave_idle, clock, reset, req_valid && !req_stall, state_ff != ffsa_pkg::S_IDLE, "accepted request did not start")
   `FFSA_ASSERT_IMP(a_err_addr_zero, clock, reset, rsp_valid_ff && (rsp_st_ff != ffsa_pkg::ST_OK), rsp_addr_ff == '0, "error response with nonzero address")
   `FFSA_ASSERT_IMP(a_wr_in_table, clock, reset, ram_we && (state_ff != ffsa_pkg::S_INIT), CW'(wr_idx) <= cnt_ff, "table write beyond segment count")

endmodule

`default_nettype wire

// ===== hw/rtl/ffsa_ram.sv =====
`default_nettype none

module ffsa_ram #(
   parameter int WIDTH = 22,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire
